### rtl/pss_pkg.sv
// shared types and constants for the positional sequence store
`timescale 1ns / 1ps

package pss_pkg;

    localparam int CAPACITY = 64;
    localparam int DATA_W   = 32;
    localparam int POS_W    = 7;
    localparam int LEN_W    = 7;
    localparam int IDX_W    = $clog2(CAPACITY);

    typedef enum logic [1:0] {
        OP_READ   = 2'd0,
        OP_INSERT = 2'd1,
        OP_REMOVE = 2'd2
    } op_t;

    // broadcast from the controller to every cell
    typedef struct packed {
        logic              ins;
        logic              rem;
        logic [POS_W-1:0]  pos;
        logic [DATA_W-1:0] value;
    } cell_ctrl_t;

endpackage

### rtl/pss_cell.sv
// one storage cell of the chain: holds, takes its left or right neighbor, or loads
`timescale 1ns / 1ps

module pss_cell (
    input  logic                              clk,
    input  pss_pkg::cell_ctrl_t               ctrl,
    input  logic [pss_pkg::IDX_W-1:0]         idx,
    input  logic [pss_pkg::DATA_W-1:0]        left,
    input  logic [pss_pkg::DATA_W-1:0]        right,
    output logic [pss_pkg::DATA_W-1:0]        q,
    output logic [pss_pkg::DATA_W-1:0]        sel
);

    logic [pss_pkg::DATA_W-1:0] cell_reg;
    logic [pss_pkg::DATA_W-1:0] cell_next;
    logic [pss_pkg::POS_W-1:0]  idx_ext;
    logic                       at_pos;
    logic                       after_pos;

    assign idx_ext   = pss_pkg::POS_W'(idx);
    assign at_pos    = (idx_ext == ctrl.pos);
    assign after_pos = (idx_ext > ctrl.pos);

    always_comb
    begin
        cell_next = cell_reg;
        if (ctrl.ins)
        begin
            if (after_pos)
                cell_next = left;
            else if (at_pos)
                cell_next = ctrl.value;
        end
        else if (ctrl.rem)
        begin
            // entries at and behind the position close up
            if (after_pos || at_pos)
                cell_next = right;
        end
    end

    always_ff @(posedge clk)
    begin
        cell_reg <= cell_next;
    end

    assign q   = cell_reg;
    assign sel = at_pos ? cell_reg : '0;

endmodule

### rtl/positional_sequence_store.sv
// top level: request decode, cell chain and result register
`timescale 1ns / 1ps

// Ordered store of up to 64 signed 32-bit values held in a row of cells.
// Shifting cells load from their neighbor in the same cycle, so a read, insert
// or remove is done in a single step and a new request can be transferred
// every cycle while the result register is empty or being taken. A result is
// registered, appears in the cycle after its transfer and stays until taken;
// a stalled result holds off the input. Rejected requests (position out of
// range, insert while full, unused operation code) set error, return zero
// and leave the store unchanged. count reports the length after the request.

module positional_sequence_store (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [1:0]                        operation,
    input  logic [pss_pkg::POS_W-1:0]         position,
    input  logic signed [pss_pkg::DATA_W-1:0] value,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic signed [pss_pkg::DATA_W-1:0] item_out,
    output logic [pss_pkg::LEN_W-1:0]         count,
    output logic                              error
);

    localparam logic [pss_pkg::LEN_W-1:0] FULL = pss_pkg::LEN_W'(pss_pkg::CAPACITY);

    logic                         take;
    logic [pss_pkg::LEN_W-1:0]    len_reg;
    logic [pss_pkg::LEN_W-1:0]    len_next;
    logic                         out_valid_reg;
    logic                         out_valid_next;
    logic [pss_pkg::DATA_W-1:0]   item_reg;
    logic [pss_pkg::DATA_W-1:0]   item_next;
    logic                         error_reg;
    logic                         error_next;
    logic                         req_err;
    logic [pss_pkg::DATA_W-1:0]   read_val;
    pss_pkg::cell_ctrl_t          ctrl;
    logic [pss_pkg::DATA_W-1:0]   cell_q   [pss_pkg::CAPACITY];
    logic [pss_pkg::DATA_W-1:0]   cell_sel [pss_pkg::CAPACITY];

    assign in_ready = !out_valid_reg || out_ready;
    assign take     = in_valid && in_ready;

    always_comb
    begin
        case (operation)
            pss_pkg::OP_READ,
            pss_pkg::OP_REMOVE: req_err = (position >= len_reg);
            pss_pkg::OP_INSERT: req_err = (position > len_reg) || (len_reg == FULL);
            default:            req_err = 1'b1;
        endcase
    end

    always_comb
    begin
        ctrl.ins   = take && !req_err && (operation == pss_pkg::OP_INSERT);
        ctrl.rem   = take && !req_err && (operation == pss_pkg::OP_REMOVE);
        ctrl.pos   = position;
        ctrl.value = value;
    end

    // only the cell at the position drives a nonzero value
    always_comb
    begin
        read_val = '0;
        for (int i = 0; i < pss_pkg::CAPACITY; i++)
            read_val = read_val | cell_sel[i];
    end

    genvar g;
    generate
        for (g = 0; g < pss_pkg::CAPACITY; g++)
        begin : g_cell
            logic [pss_pkg::DATA_W-1:0] left_w;
            logic [pss_pkg::DATA_W-1:0] right_w;
            if (g == 0)
            begin : g_first
                assign left_w = '0;
            end
            else
            begin : g_mid_l
                assign left_w = cell_q[g-1];
            end
            if (g == pss_pkg::CAPACITY - 1)
            begin : g_last
                assign right_w = '0;
            end
            else
            begin : g_mid_r
                assign right_w = cell_q[g+1];
            end
            pss_cell u_cell (
                .clk   (clk),
                .ctrl  (ctrl),
                .idx   (pss_pkg::IDX_W'(g)),
                .left  (left_w),
                .right (right_w),
                .q     (cell_q[g]),
                .sel   (cell_sel[g])
            );
        end
    endgenerate

    always_comb
    begin
        len_next       = len_reg;
        out_valid_next = out_valid_reg;
        item_next      = item_reg;
        error_next     = error_reg;
        if (take)
        begin
            out_valid_next = 1'b1;
            error_next     = req_err;
            item_next      = '0;
            if (ctrl.ins)
                len_next = len_reg + 1'b1;
            if (ctrl.rem)
                len_next = len_reg - 1'b1;
            if (!req_err && (operation != pss_pkg::OP_INSERT))
                item_next = read_val;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            len_reg       <= len_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg  <= item_next;
        error_reg <= error_next;
    end

    assign out_valid = out_valid_reg;
    assign item_out  = item_reg;
    assign error     = error_reg;
    // length register shows the count after the last transferred request
    assign count     = len_reg;

endmodule

### rtl/pss_checker.sv
// port-level checks for the positional sequence store, bound to the top level
`timescale 1ns / 1ps

module pss_checker (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              in_valid,
    input logic                              in_ready,
    input logic                              out_valid,
    input logic                              out_ready,
    input logic signed [pss_pkg::DATA_W-1:0] item_out,
    input logic [pss_pkg::LEN_W-1:0]         count,
    input logic                              error
);

    // stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(item_out) && $stable(error)
            && $stable(count))
        else $error("result changed while stalled");

    // rejected requests return zero
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && error |-> item_out == '0)
        else $error("error result carries nonzero item");

    a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> count <= pss_pkg::LEN_W'(pss_pkg::CAPACITY))
        else $error("count beyond capacity");

    // a waiting result blocks new transfers
    a_stall_input: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |-> !in_ready)
        else $error("input taken while result stalled");

    // each transfer yields a result in the next cycle
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> out_valid)
        else $error("no result after transfer");

endmodule

bind positional_sequence_store pss_checker u_pss_checker (.*);

### tb/sv/tb_positional_sequence_store.sv
// self-checking testbench for the positional sequence store
`timescale 1ns / 1ps

module tb_positional_sequence_store;

    import pss_pkg::*;

    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam int IDLE_PCT = 34;
    localparam int RANDOM_ITEMS = 1500;

    typedef struct {
        logic [1:0]               op;
        logic [POS_W-1:0]         pos;
        logic signed [DATA_W-1:0] val;
        bit                       drain;
    } request_t;

    typedef struct {
        logic signed [DATA_W-1:0] item;
        logic [LEN_W-1:0]         count;
        logic                     error;
    } result_t;

    logic                       clk;
    logic                       rst_n;
    logic                       in_valid;
    logic                       in_ready;
    logic [1:0]                 operation;
    logic [POS_W-1:0]           position;
    logic signed [DATA_W-1:0]   value;
    logic                       out_valid;
    logic                       out_ready;
    logic signed [DATA_W-1:0]   item_out;
    logic [LEN_W-1:0]           count;
    logic                       error;

    request_t request_queue[$];
    result_t  results_due[$];

    // mirror of the store contents
    logic signed [DATA_W-1:0] seq_cells [CAPACITY];
    int                       seq_len;

    // length as the stimulus generator sees it
    int gen_len;

    int  mismatches;
    int  cyc;
    bit  calm;

    positional_sequence_store dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .operation (operation),
        .position  (position),
        .value     (value),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .item_out  (item_out),
        .count     (count),
        .error     (error)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    function automatic result_t apply_request(logic [1:0] op, logic [POS_W-1:0] pos,
                                              logic signed [DATA_W-1:0] val);
        result_t r;
        int      p;
        int      i;
        r.item  = '0;
        r.error = 1'b0;
        p = int'(pos);
        case (op)
            OP_READ:
            begin
                if (p >= seq_len)
                    r.error = 1'b1;
                else
                    r.item = seq_cells[p];
            end
            OP_INSERT:
            begin
                if (p > seq_len || seq_len >= CAPACITY)
                    r.error = 1'b1;
                else
                begin
                    for (i = seq_len; i > p; i--)
                        seq_cells[i] = seq_cells[i-1];
                    seq_cells[p] = val;
                    seq_len++;
                end
            end
            OP_REMOVE:
            begin
                if (p >= seq_len)
                    r.error = 1'b1;
                else
                begin
                    r.item = seq_cells[p];
                    for (i = p; i < seq_len - 1; i++)
                        seq_cells[i] = seq_cells[i+1];
                    seq_len--;
                end
            end
            default:
                r.error = 1'b1;
        endcase
        r.count = seq_len[LEN_W-1:0];
        return r;
    endfunction

    task automatic add_request(logic [1:0] op, int pos, logic signed [DATA_W-1:0] val,
                               bit drain);
        request_t rq;
        rq.op    = op;
        rq.pos   = pos[POS_W-1:0];
        rq.val   = val;
        rq.drain = drain;
        request_queue.push_back(rq);
        if (op == OP_INSERT && rq.pos <= gen_len && gen_len < CAPACITY)
            gen_len++;
        else if (op == OP_REMOVE && rq.pos < gen_len)
            gen_len--;
    endtask

    always @(posedge clk)
    begin
        cyc  <= cyc + 1;
        calm <= (cyc >= 2000 && cyc < 3500);
    end

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid  <= 1'b0;
            operation <= OP_READ;
            position  <= '0;
            value     <= '0;
        end
        else
        begin
            if (in_valid && in_ready)
                results_due.push_back(apply_request(operation, position, value));
            if (!in_valid || in_ready)
            begin
                if (request_queue.size() > 0
                    && (calm || $urandom_range(0, 99) >= IDLE_PCT)
                    && !(request_queue[0].drain && results_due.size() != 0))
                begin
                    in_valid  <= 1'b1;
                    operation <= request_queue[0].op;
                    position  <= request_queue[0].pos;
                    value     <= request_queue[0].val;
                    void'(request_queue.pop_front());
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge clk or negedge rst_n)
    begin
        result_t want;
        if (!rst_n)
            out_ready <= 1'b0;
        else
        begin
            if (out_valid && out_ready)
            begin
                if (results_due.size() == 0)
                begin
                    mismatches++;
                    $display("%0t: result with nothing expected: item %0d count %0d error %0b",
                             $time, item_out, count, error);
                end
                else
                begin
                    want = results_due.pop_front();
                    if (item_out !== want.item)
                    begin
                        mismatches++;
                        $display("%0t: item_out expected %0d actual %0d",
                                 $time, want.item, item_out);
                    end
                    if (count !== want.count)
                    begin
                        mismatches++;
                        $display("%0t: count expected %0d actual %0d",
                                 $time, want.count, count);
                    end
                    if (error !== want.error)
                    begin
                        mismatches++;
                        $display("%0t: error expected %0b actual %0b",
                                 $time, want.error, error);
                    end
                end
            end
            out_ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    initial
    begin
        int         n_random;
        int         mode;
        int         seg_items;
        int         roll;
        int         pos;
        int         k;
        logic [1:0] op;
        logic signed [DATA_W-1:0] val;

        rst_n      = 1'b0;
        mismatches = 0;
        seq_len    = 0;
        gen_len    = 0;
        n_random   = 0;

        // directed: empty store, extremes, every operation, out-of-range and unused-code rejections
        add_request(OP_READ,   0, 32'sd0, 1'b0);
        add_request(OP_REMOVE, 0, 32'sd0, 1'b0);
        add_request(OP_INSERT, 1, 32'sd5, 1'b0);
        add_request(OP_INSERT, 0, 32'sh80000000, 1'b0);
        add_request(OP_INSERT, 1, 32'sh7fffffff, 1'b0);
        add_request(OP_INSERT, 1, 32'sd0, 1'b0);
        add_request(OP_INSERT, 0, -32'sd1, 1'b0);
        for (k = 0; k < 4; k++)
            add_request(OP_READ, k, 32'sd0, 1'b0);
        add_request(OP_READ,   4, 32'sd0, 1'b0);
        add_request(OP_INSERT, 5, 32'sd7, 1'b0);
        add_request(OP_UNUSED, 0, 32'sd0, 1'b0);
        add_request(OP_READ,   127, 32'sd0, 1'b0);
        add_request(OP_INSERT, 64, 32'sd1, 1'b0);
        add_request(OP_REMOVE, 64, 32'sd0, 1'b0);
        add_request(OP_REMOVE, 3, 32'sd0, 1'b0);
        add_request(OP_REMOVE, 0, 32'sd0, 1'b0);
        add_request(OP_READ,   1, 32'sd0, 1'b0);
        add_request(OP_REMOVE, 1, 32'sd0, 1'b0);
        add_request(OP_REMOVE, 0, 32'sd0, 1'b0);
        add_request(OP_READ,   0, 32'sd0, 1'b0);

        // random segments; the first one issues 70 inserts to drive the store toward capacity, then reads
        mode = 4;
        while (n_random < RANDOM_ITEMS)
        begin
            seg_items = (mode == 4) ? 80 : $urandom_range(40, 120);
            for (k = 0; k < seg_items; k++)
            begin
                roll = $urandom_range(0, 99);
                case (mode)
                    0: op = (roll < 70) ? OP_INSERT : (roll < 85) ? OP_READ : OP_REMOVE;
                    1: op = (roll < 70) ? OP_REMOVE : (roll < 85) ? OP_READ : OP_INSERT;
                    2: op = (roll < 34) ? OP_INSERT : (roll < 67) ? OP_READ : OP_REMOVE;
                    3: op = 2'($urandom_range(0, 3));
                    default: op = (k < 70) ? OP_INSERT : OP_READ;
                endcase
                if (mode == 3 || $urandom_range(0, 99) < 8)
                    pos = $urandom_range(0, 127);
                else if (op == OP_INSERT)
                    pos = $urandom_range(0, gen_len);
                else
                    pos = (gen_len == 0) ? 0 : $urandom_range(0, gen_len - 1);
                roll = $urandom_range(0, 15);
                val = (roll == 0) ? 32'sh80000000 : (roll == 1) ? 32'sh7fffffff :
                      (roll == 2) ? 32'sd0 : (roll == 3) ? -32'sd1 : $urandom();
                // on every 300th request the sender holds off until the store has answered everything
                add_request(op, pos, val, (n_random % 300) == 0);
                n_random++;
            end
            mode = $urandom_range(0, 3);
        end

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (request_queue.size() != 0 || in_valid || results_due.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (mismatches == 0)
            $display("tb_positional_sequence_store OK");
        else
            $display("tb_positional_sequence_store NOT OK");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("tb_positional_sequence_store NOT OK");
        $finish;
    end

endmodule

### filelist.f
rtl/pss_pkg.sv
rtl/pss_cell.sv
rtl/positional_sequence_store.sv
rtl/pss_checker.sv
tb/sv/tb_positional_sequence_store.sv
